// ===== design/spfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spfc_pkg
// Shared types and codes for the SPI flash command master.
// ----------------------------------------------------------------------------
package spfc_pkg;

    // Item kinds, decided by the front end
    localparam logic [1:0] K_TICK  = 2'd0;
    localparam logic [1:0] K_START = 2'd1;
    localparam logic [1:0] K_BAD   = 2'd2;

    // Command numbers
    localparam logic [2:0] CMD_WREN  = 3'd0;
    localparam logic [2:0] CMD_PROG  = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_RDSR  = 3'd3;
    localparam logic [2:0] CMD_ERASE = 3'd4;
    localparam logic [2:0] CMD_LAST  = CMD_ERASE;

    // Back end phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;
    localparam logic [1:0] PH_GAP  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_WREN_OPC  = 2'd0;
    localparam logic [1:0] CFG_ERASE_OPC = 2'd1;
    localparam logic [1:0] CFG_RDSR_OPC  = 2'd2;

    localparam logic [7:0] RST_WREN_OPC  = 8'h06;
    localparam logic [7:0] RST_ERASE_OPC = 8'h60;
    localparam logic [7:0] RST_RDSR_OPC  = 8'h05;

    // Bits received per read
    localparam int RX_BITS = 8;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] cmd;
        logic       miso;
    } t_item;

    typedef struct packed {
        logic       chip_select_n;
        logic       mosi;
        logic       clock_pulse;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       rejected;
    } t_result;

    typedef struct packed {
        logic [7:0] wren;
        logic [7:0] erase;
        logic [7:0] rdsr;
    } t_opcodes;

endpackage : spfc_pkg
`default_nettype wire

// ===== design/spfc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spfc_front
// Accepts items, classifies them, builds the address frame and queues them.
// ----------------------------------------------------------------------------
module spfc_front
    import spfc_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_operation,
    input  wire logic [2:0]             i_command,
    input  wire logic [7:0]             i_opcode,
    input  wire logic [23:0]            i_address,
    input  wire logic [7:0]             i_write_data,
    input  wire logic                   i_miso,
    output logic                        o_q_valid,
    input  wire logic                   i_q_pop,
    output t_item                       o_q_item,
    output logic [ADDR_BITS+15:0]       o_q_word
);

    localparam int SW = ADDR_BITS + 16;

    t_item                   w_item;
    logic [ADDR_BITS+23:0]   w_addr_ext;
    logic [SW-1:0]           w_word;
    logic                    w_push;

    // two entry queue
    t_item                   r_item_q [2];
    logic [SW-1:0]           r_word_q [2];
    logic                    r_wptr;
    logic                    r_rptr;
    logic [1:0]              r_count;
    logic [1:0]              n_count;

    always_comb begin
        w_item.miso = i_miso;
        w_item.cmd  = i_command;
        if (!i_operation) begin
            w_item.kind = K_TICK;
        end else if (i_command > CMD_LAST) begin
            w_item.kind = K_BAD;
        end else begin
            w_item.kind = K_START;
        end
        w_addr_ext = {{ADDR_BITS{1'b0}}, i_address};
        // opcode, address, data, left aligned; read sends all but the data byte
        w_word = {i_opcode, w_addr_ext[ADDR_BITS-1:0], i_write_data};
    end

    assign o_in_ready = (r_count != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_item_q[r_rptr];
    assign o_q_word   = r_word_q[r_rptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_item_q[r_wptr] <= w_item;
            r_word_q[r_wptr] <= w_word;
        end
    end

endmodule : spfc_front
`default_nettype wire

// ===== design/spfc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spfc_back
// Command sequencer: runs one bit slot per item and registers the result.
// ----------------------------------------------------------------------------
module spfc_back
    import spfc_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    output logic                        o_q_pop,
    input  wire t_item                  i_q_item,
    input  wire logic [ADDR_BITS+15:0]  i_q_word,
    input  wire t_opcodes               i_opc,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_result                     o_res
);

    localparam int SW = ADDR_BITS + 16;
    localparam int CW = $clog2(SW + 1);

    logic [1:0]     r_phase,  n_phase;
    logic [CW-1:0]  r_cnt,    n_cnt;
    logic [SW-1:0]  r_shift,  n_shift;
    logic [7:0]     r_in,     n_in;
    logic [2:0]     r_cmd,    n_cmd;
    logic           r_poll,   n_poll;
    logic           r_valid;
    t_result        r_res,    n_res;
    logic [7:0]     w_in_new;

    assign o_q_pop     = i_q_valid && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_in     = r_in;
        n_cmd    = r_cmd;
        n_poll   = r_poll;
        n_res    = '0;
        n_res.chip_select_n = 1'b1;
        w_in_new = {r_in[6:0], i_q_item.miso};

        case (i_q_item.kind)
            K_START: begin
                if (r_phase != PH_IDLE) begin
                    n_res.chip_select_n = !(r_phase == PH_SEND || r_phase == PH_RECV);
                    n_res.busy          = 1'b1;
                    n_res.rejected      = 1'b1;
                end else begin
                    n_res.busy = 1'b1;
                    n_cmd      = i_q_item.cmd;
                    n_poll     = 1'b0;
                    n_in       = '0;
                    n_phase    = PH_SEND;
                    unique case (i_q_item.cmd)
                        CMD_WREN: begin
                            n_shift = {i_opc.wren, {(SW-8){1'b0}}};
                            n_cnt   = CW'(8);
                        end
                        CMD_PROG: begin
                            n_shift = i_q_word;
                            n_cnt   = CW'(SW);
                        end
                        CMD_READ: begin
                            n_shift = i_q_word;
                            n_cnt   = CW'(SW - 8);
                        end
                        CMD_RDSR: begin
                            n_shift = {i_opc.rdsr, {(SW-8){1'b0}}};
                            n_cnt   = CW'(8);
                        end
                        default: begin
                            n_shift = {i_opc.erase, {(SW-8){1'b0}}};
                            n_cnt   = CW'(8);
                        end
                    endcase
                end
            end
            K_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_GAP: begin
                        // CS high for one slot, then the next status poll
                        n_res.busy = 1'b1;
                        n_shift    = {i_opc.rdsr, {(SW-8){1'b0}}};
                        n_cnt      = CW'(8);
                        n_phase    = PH_SEND;
                    end
                    PH_SEND: begin
                        n_res.chip_select_n = 1'b0;
                        n_res.clock_pulse   = 1'b1;
                        n_res.busy          = 1'b1;
                        n_res.mosi          = r_shift[SW-1];
                        n_shift             = r_shift << 1;
                        n_cnt               = r_cnt - CW'(1);
                        if (r_cnt <= CW'(1)) begin
                            if (r_cmd == CMD_WREN || r_cmd == CMD_PROG) begin
                                n_res.done = 1'b1;
                                n_phase    = PH_IDLE;
                                n_cnt      = '0;
                                n_poll     = 1'b0;
                            end else if (r_cmd == CMD_ERASE && !r_poll) begin
                                n_poll  = 1'b1;
                                n_phase = PH_GAP;
                            end else begin
                                n_phase = PH_RECV;
                                n_cnt   = CW'(RX_BITS);
                                n_in    = '0;
                            end
                        end
                    end
                    default: begin
                        n_res.chip_select_n = 1'b0;
                        n_res.clock_pulse   = 1'b1;
                        n_res.busy          = 1'b1;
                        n_in                = w_in_new;
                        if (r_cnt != '0) begin
                            n_cnt = r_cnt - CW'(1);
                        end
                        if (r_cnt <= CW'(1)) begin
                            if (r_cmd == CMD_ERASE && w_in_new[0]) begin
                                n_phase = PH_GAP;
                            end else begin
                                n_res.done      = 1'b1;
                                n_res.read_data = w_in_new;
                                n_phase         = PH_IDLE;
                                n_cnt           = '0;
                                n_poll          = 1'b0;
                            end
                        end
                    end
                endcase
            end
            default: begin
                // unknown command: refused while busy, else an idle slot result
                if (r_phase != PH_IDLE) begin
                    n_res.chip_select_n = !(r_phase == PH_SEND || r_phase == PH_RECV);
                    n_res.busy          = 1'b1;
                    n_res.rejected      = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_in    <= '0;
            r_cmd   <= '0;
            r_poll  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_shift <= n_shift;
                r_in    <= n_in;
                r_cmd   <= n_cmd;
                r_poll  <= n_poll;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

endmodule : spfc_back
`default_nettype wire

// ===== design/spi_flash_command_master.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spi_flash_command_master
// SPI mode-0 command master for a serial NOR flash, one bit slot per item.
// ----------------------------------------------------------------------------
// A start item (operation 1) launches write enable, program byte, read byte,
// read status or chip erase; every tick item (operation 0) is one serial bit
// slot and returns the chip select level, the MOSI bit, whether SCK pulses,
// and busy/done/read data. Fields go out MSB first; chip erase polls status
// with a CS-high gap slot between polls until bit 0 reads clear. Every item,
// start or tick, gives exactly one result. Throughput is one item per clock:
// the front end classifies items into a two-entry queue and the back end
// sequencer updates its state and fills the output register once for each
// item, so the output register's ready is what sets the pace. A result is
// registered: an accepted item waits in the queue until the output register
// can take it, then moves into the output register. Opcode registers are
// written through the configuration channel, which is always ready; index 3
// is accepted and ignored. ADDR_BITS sets how many address bits are sent.
// ----------------------------------------------------------------------------
module spi_flash_command_master
    import spfc_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data,
    // items in
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic         i_operation,
    input  wire logic [2:0]   i_command,
    input  wire logic [7:0]   i_opcode,
    input  wire logic [23:0]  i_address,
    input  wire logic [7:0]   i_write_data,
    input  wire logic         i_miso,
    // results out
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic              o_chip_select_n,
    output logic              o_mosi,
    output logic              o_clock_pulse,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [7:0]        o_read_data,
    output logic              o_rejected
);

    t_opcodes                r_opc;
    logic                    w_q_valid;
    logic                    w_q_pop;
    t_item                   w_q_item;
    logic [ADDR_BITS+15:0]   w_q_word;
    t_result                 w_res;

    // Opcode registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opc.wren  <= RST_WREN_OPC;
            r_opc.erase <= RST_ERASE_OPC;
            r_opc.rdsr  <= RST_RDSR_OPC;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WREN_OPC:  r_opc.wren  <= i_cfg_data;
                CFG_ERASE_OPC: r_opc.erase <= i_cfg_data;
                CFG_RDSR_OPC:  r_opc.rdsr  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: classify and queue
    spfc_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_command    (i_command),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_miso       (i_miso),
        .o_q_valid    (w_q_valid),
        .i_q_pop      (w_q_pop),
        .o_q_item     (w_q_item),
        .o_q_word     (w_q_word)
    );

    // Back end: bit slot sequencer and output register
    spfc_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_item    (w_q_item),
        .i_q_word    (w_q_word),
        .i_opc       (r_opc),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_res)
    );

    assign o_chip_select_n = w_res.chip_select_n;
    assign o_mosi          = w_res.mosi;
    assign o_clock_pulse   = w_res.clock_pulse;
    assign o_busy_res      = w_res.busy;
    assign o_done_res      = w_res.done;
    assign o_read_data     = w_res.read_data;
    assign o_rejected      = w_res.rejected;

endmodule : spi_flash_command_master
`default_nettype wire

// ===== test/spi_flash_command_master_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_flash_command_master_test
// Self-checking bench for the SPI flash command master.
// ----------------------------------------------------------------------------
// Start and tick items go in with random gaps while the result side stalls at
// random. A scoreboard carries its own cycle-free model of the command
// sequencer (send, receive and erase-poll gap slots) and checks every result
// slot in order. The opcode registers are rewritten between phases, with the
// all-zero and all-one settings among them, and the run ends back on the
// reset opcodes.
// ----------------------------------------------------------------------------
module spi_flash_command_master_test;
    import spfc_pkg::*;

    // Operation field
    localparam logic       OP_TICK  = 1'b0;
    localparam logic       OP_START = 1'b1;
    // Command numbers outside the legal set
    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;
    // Index with no register behind it; the block takes it and drops it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic        op;
        logic [2:0]  cmd;
        logic [7:0]  opcode;
        logic [23:0] address;
        logic [7:0]  wdata;
        logic        miso;
    } flash_item_t;

    // ------------------------------------------------------------------------
    // Scoreboard: slot-accurate model of the sequencer plus the queue of
    // results still owed by the block.
    // ------------------------------------------------------------------------
    class flash_scoreboard;
        logic [7:0]  wren_opc;
        logic [7:0]  erase_opc;
        logic [7:0]  rdsr_opc;
        logic [1:0]  phase;
        int unsigned bits_left;
        logic [63:0] tx_bits;
        logic [7:0]  rx_byte;
        logic [2:0]  cur_cmd;
        bit          polling;
        t_result     owed_q[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            wren_opc  = RST_WREN_OPC;
            erase_opc = RST_ERASE_OPC;
            rdsr_opc  = RST_RDSR_OPC;
            phase     = PH_IDLE;
            bits_left = 0;
            tx_bits   = '0;
            rx_byte   = '0;
            cur_cmd   = CMD_WREN;
            polling   = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_WREN_OPC:  wren_opc  = val;
                CFG_ERASE_OPC: erase_opc = val;
                CFG_RDSR_OPC:  rdsr_opc  = val;
                default: ;
            endcase
        endfunction

        function bit is_idle();
            return phase == PH_IDLE;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void load_tx(logic [63:0] bits, int unsigned n);
            tx_bits   = bits;
            bits_left = n;
            phase     = PH_SEND;
        endfunction

        function void end_command(inout t_result r, input bit with_data);
            r.done      = 1'b1;
            r.read_data = with_data ? rx_byte : 8'h00;
            phase       = PH_IDLE;
            bits_left   = 0;
            polling     = 1'b0;
        endfunction

        // One item in, one slot result out
        function t_result slot_result(flash_item_t it);
            t_result r;
            r = '0;
            r.chip_select_n = 1'b1;
            if (it.op == OP_START) begin
                if (phase != PH_IDLE) begin
                    // CS stays low only inside a send or receive
                    r.chip_select_n = (phase == PH_SEND || phase == PH_RECV) ? 1'b0 : 1'b1;
                    r.busy     = 1'b1;
                    r.rejected = 1'b1;
                    return r;
                end
                if (it.cmd > CMD_LAST) return r;
                cur_cmd = it.cmd;
                polling = 1'b0;
                rx_byte = '0;
                case (it.cmd)
                    CMD_WREN: load_tx({56'd0, wren_opc}, 8);
                    CMD_PROG: load_tx({24'd0, it.opcode, it.address, it.wdata}, 40);
                    CMD_READ: load_tx({32'd0, it.opcode, it.address}, 32);
                    CMD_RDSR: load_tx({56'd0, rdsr_opc}, 8);
                    default:  load_tx({56'd0, erase_opc}, 8);
                endcase
                r.busy = 1'b1;
                return r;
            end
            if (phase == PH_IDLE) return r;
            r.busy = 1'b1;
            if (phase == PH_GAP) begin
                // poll opcode taken as it stands now
                load_tx({56'd0, rdsr_opc}, 8);
                return r;
            end
            r.chip_select_n = 1'b0;
            r.clock_pulse   = 1'b1;
            if (phase == PH_SEND) begin
                r.mosi = tx_bits[bits_left - 1];
                bits_left--;
                if (bits_left == 0) begin
                    if (cur_cmd == CMD_WREN || cur_cmd == CMD_PROG) begin
                        end_command(r, 1'b0);
                    end else if (cur_cmd == CMD_ERASE && !polling) begin
                        polling = 1'b1;
                        phase   = PH_GAP;
                    end else begin
                        phase     = PH_RECV;
                        bits_left = RX_BITS;
                        rx_byte   = '0;
                    end
                end
                return r;
            end
            rx_byte = {rx_byte[6:0], it.miso};
            bits_left--;
            if (bits_left == 0) begin
                if (cur_cmd == CMD_ERASE && rx_byte[0]) phase = PH_GAP;
                else end_command(r, 1'b1);
            end
            return r;
        endfunction

        function void note_item(flash_item_t it);
            owed_q.push_back(slot_result(it));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with no item outstanding: %b", got);
                return;
            end
            want = owed_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: result %0d expected cs_n %b mosi %b sck %b busy %b done %b data %h rej %b",
                             checked, want.chip_select_n, want.mosi, want.clock_pulse,
                             want.busy, want.done, want.read_data, want.rejected);
                    $display("       result %0d actual   cs_n %b mosi %b sck %b busy %b done %b data %h rej %b",
                             checked, got.chip_select_n, got.mosi, got.clock_pulse,
                             got.busy, got.done, got.read_data, got.rejected);
                end
            end
            checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [2:0]  i_command;
    logic [7:0]  i_opcode;
    logic [23:0] i_address;
    logic [7:0]  i_write_data;
    logic        i_miso;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_chip_select_n;
    logic        o_mosi;
    logic        o_clock_pulse;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_data;
    logic        o_rejected;

    spi_flash_command_master dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_command       (i_command),
        .i_opcode        (i_opcode),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_miso          (i_miso),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_chip_select_n (o_chip_select_n),
        .o_mosi          (o_mosi),
        .o_clock_pulse   (o_clock_pulse),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_read_data     (o_read_data),
        .o_rejected      (o_rejected)
    );

    flash_scoreboard sb;
    int unsigned     items_sent   = 0;
    int unsigned     results_seen = 0;
    bit              quiet        = 1'b0;   // sender runs back to back while set

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #6_000_000;
        $display("spi_flash_command_master: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side backpressure. Mostly long ready runs with short or long
    // drops; once, after a few hundred results, ready is held low for a long
    // stretch so the block fills up and pushes back on the sender.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned run;
        int unsigned r;
        bit          level;
        bit          held_off;
        held_off = 1'b0;
        forever begin
            if (!held_off && results_seen >= 300) begin
                held_off = 1'b1;
                level    = 1'b0;
                run      = 400;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    level = 1'b1;
                    run   = $urandom_range(1, 40);
                end else if (r < 90) begin
                    level = 1'b0;
                    run   = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    run   = $urandom_range(8, 30);
                end
            end
            i_out_ready <= level;
            repeat (run) @(posedge i_clk);
        end
    end

    // Every accepted result goes straight to the scoreboard
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_chip_select_n, o_mosi, o_clock_pulse, o_busy_res, o_done_res,
                   o_read_data, o_rejected};
            sb.check_result(got);
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    // Gap before an item: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Field values biased toward the ends of the range
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return 8'h00;
        if (r < 24) return 8'hFF;
        if (r < 30) return 8'h80;
        return 8'($urandom);
    endfunction

    function automatic logic [23:0] pick_addr();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 24'h000000;
        if (r < 20) return 24'hFFFFFF;
        if (r < 28) return 24'h800000;
        if (r < 32) return 24'h000001;
        return 24'($urandom);
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(input flash_item_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= it.op;
        i_command    <= it.cmd;
        i_opcode     <= it.opcode;
        i_address    <= it.address;
        i_write_data <= it.wdata;
        i_miso       <= it.miso;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    // Tick: one bit slot; the unused fields carry noise
    task automatic send_tick(input logic miso);
        flash_item_t it;
        it.op      = OP_TICK;
        it.cmd     = 3'($urandom);
        it.opcode  = 8'($urandom);
        it.address = 24'($urandom);
        it.wdata   = 8'($urandom);
        it.miso    = miso;
        send_item(it);
    endtask

    task automatic send_start(input logic [2:0] cmd, input logic [7:0] opc,
                              input logic [23:0] addr, input logic [7:0] wd);
        flash_item_t it;
        it.op      = OP_START;
        it.cmd     = cmd;
        it.opcode  = opc;
        it.address = addr;
        it.wdata   = wd;
        it.miso    = 1'($urandom);
        send_item(it);
    endtask

    // Whole command: start, then ticks until the model says it is over.
    // Random MISO ends an erase poll half the time, so erases stay short.
    // With noisy set, a stray start lands now and then while busy.
    task automatic run_command(input logic [2:0] cmd, input bit noisy);
        int unsigned n;
        send_start(cmd, pick_byte(), pick_addr(), pick_byte());
        n = 0;
        while (!sb.is_idle() && n < 5000) begin
            if (noisy && $urandom_range(0, 99) < 3)
                send_start(3'($urandom_range(0, 7)), 8'($urandom), 24'($urandom),
                           8'($urandom));
            else
                send_tick(1'($urandom_range(0, 1)));
            n++;
        end
    endtask

    // Stop offering, wait for every owed result, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Rewrite all opcode registers (and the spare index) with the block idle
    task automatic configure(input logic [7:0] wren, input logic [7:0] erase,
                             input logic [7:0] rdsr);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        drain();
        idx = '{CFG_WREN_OPC, CFG_ERASE_OPC, CFG_RDSR_OPC, CFG_SPARE};
        val = '{wren, erase, rdsr, 8'($urandom)};
        foreach (idx[k]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_register(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned r;
        int          p;
        logic [2:0]  cmd;

        sb = new();
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_operation  <= OP_TICK;
        i_command    <= CMD_WREN;
        i_opcode     <= '0;
        i_address    <= '0;
        i_write_data <= '0;
        i_miso       <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_WREN_OPC;
        i_cfg_data   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset opcodes: idle slot, illegal commands,
        // write enable with a start refused mid-send, then a status read
        // of all ones.
        send_tick(1'b1);
        send_start(CMD_BAD_LO, 8'h00, 24'h000000, 8'h00);
        send_start(CMD_BAD_HI, 8'hFF, 24'hFFFFFF, 8'hFF);
        send_start(CMD_WREN, 8'h00, 24'h000000, 8'h00);
        send_tick(1'b0);
        send_tick(1'b1);
        send_start(CMD_PROG, 8'hFF, 24'hFFFFFF, 8'hFF);
        while (!sb.is_idle()) send_tick(1'b0);
        send_start(CMD_RDSR, 8'h00, 24'h000000, 8'h00);
        while (!sb.is_idle()) send_tick(1'b1);

        // Random phases, each under its own opcode setting
        for (p = 0; p < 5; p++) begin
            case (p)
                0:       configure(8'hFF, 8'hFF, 8'hFF);
                1:       configure(8'h00, 8'h00, 8'h00);
                4:       configure(RST_WREN_OPC, RST_ERASE_OPC, RST_RDSR_OPC);
                default: configure(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            while (items_sent < 40 + (p + 1) * 242) begin
                if ($urandom_range(0, 9) == 0) quiet = !quiet;
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    send_tick(1'($urandom_range(0, 1)));      // idle slot
                end else if (r < 9) begin
                    send_start(3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)),
                               8'($urandom), 24'($urandom), 8'($urandom));
                end else begin
                    r   = $urandom_range(0, 99);
                    cmd = (r < 15) ? CMD_WREN :
                          (r < 40) ? CMD_PROG :
                          (r < 65) ? CMD_READ :
                          (r < 85) ? CMD_RDSR : CMD_ERASE;
                    run_command(cmd, 1'b1);
                end
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("spi_flash_command_master: match");
        else
            $display("spi_flash_command_master: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
design/spfc_pkg.sv
design/spfc_front.sv
design/spfc_back.sv
design/spi_flash_command_master.sv
test/spi_flash_command_master_test.sv
